/* sv/jpeg_header_dimension_scan_core_assert.svh */
// Assertion macros shared by the checker of the JPEG dimension scanner.
// No dependencies; include this file by its bare name.
`ifndef JPEG_HEADER_DIMENSION_SCAN_CORE_ASSERT_SVH
`define JPEG_HEADER_DIMENSION_SCAN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JHDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jhds assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JHDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jhds assertion failed");

`endif

/* sv/jhds_pkg.sv */
// Types and constants of the JPEG dimension scanner.
// No dependencies; used by the registers, the parser, the top level and the bench.
package jhds_pkg;

    typedef enum logic [3:0] {
        PH_SOI0  = 4'd0,
        PH_SOI1  = 4'd1,
        PH_HUNT  = 4'd2,
        PH_CODE  = 4'd3,
        PH_LENHI = 4'd4,
        PH_LENLO = 4'd5,
        PH_SKIP  = 4'd6,
        PH_FRAME = 4'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_NOFRAME  = 3'd1,
        ST_BADSTART = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_BADLEN   = 3'd4
    } t_status;

    localparam logic [7:0]  C_MARK      = 8'hFF;
    localparam logic [7:0]  C_SOI       = 8'hD8;
    localparam logic [7:0]  C_EOI       = 8'hD9;
    localparam logic [7:0]  C_SOS       = 8'hDA;
    localparam logic [7:0]  C_SOF_LO    = 8'hC0;
    localparam logic [7:0]  C_SOF_HI    = 8'hCF;
    localparam logic [7:0]  C_DHT       = 8'hC4;
    localparam logic [7:0]  C_JPG       = 8'hC8;
    localparam logic [7:0]  C_DAC       = 8'hCC;
    localparam logic [15:0] C_LEN_MIN   = 16'd2;
    localparam logic [9:0]  C_FRAME_FIX = 10'd8;
    localparam logic [9:0]  C_COMP_LEN  = 10'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        t_status     status;
        logic [15:0] width;
        logic [15:0] height;
    } t_result;

endpackage

/* sv/jhds_in_reg.sv */
// Input register of the JPEG dimension scanner: holds one accepted beat.
// Depends on jhds_pkg.
module jhds_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_valid,
    input  jhds_pkg::t_beat i_beat,
    output logic            o_valid,
    output jhds_pkg::t_beat o_beat
);
    import jhds_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* sv/jhds_parser.sv */
// Marker parser of the JPEG dimension scanner: one byte per enabled cycle.
// Depends on jhds_pkg.
module jhds_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  jhds_pkg::t_beat   i_beat,
    output logic              o_res_valid,
    output jhds_pkg::t_result o_res
);
    import jhds_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_skip,      n_skip;
    logic [2:0]  r_field,     n_field;
    logic [15:0] r_seg_len,   n_seg_len;
    logic [15:0] r_height,    n_height;
    logic [15:0] r_width,     n_width;
    logic        r_concluded, n_concluded;

    t_phase      ph_eff;
    logic [2:0]  field_eff;
    logic        conc_eff;
    logic [7:0]  b;
    logic [15:0] len_word;
    logic [15:0] len_need;
    logic        is_sof;
    logic        done;
    t_status     status;

    assign b        = i_beat.data_byte;
    assign len_word = {r_seg_len[15:8], b};
    assign len_need = {6'd0, C_FRAME_FIX + {2'b00, b} * C_COMP_LEN};
    assign is_sof   = (b >= C_SOF_LO) && (b <= C_SOF_HI) &&
                      (b != C_DHT) && (b != C_JPG) && (b != C_DAC);

    // A first-byte beat restarts the parse with this very byte.
    always_comb begin
        ph_eff    = r_phase;
        field_eff = r_field;
        conc_eff  = r_concluded;
        if (i_beat.first_byte) begin
            ph_eff    = PH_SOI0;
            field_eff = 3'd0;
            conc_eff  = 1'b0;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_field     = r_field;
        n_seg_len   = r_seg_len;
        n_height    = r_height;
        n_width     = r_width;
        n_concluded = r_concluded;
        done        = 1'b0;
        status      = ST_FOUND;
        if (i_en) begin
            n_phase     = ph_eff;
            n_field     = field_eff;
            n_concluded = conc_eff;
            if (!conc_eff) begin
                unique case (ph_eff)
                    PH_SOI0: begin
                        if (b == C_MARK) begin
                            n_phase = PH_SOI1;
                        end else begin
                            done   = 1'b1;
                            status = ST_BADSTART;
                        end
                    end
                    PH_SOI1: begin
                        if (b == C_SOI) begin
                            n_phase = PH_HUNT;
                        end else begin
                            done   = 1'b1;
                            status = ST_BADSTART;
                        end
                    end
                    PH_HUNT: begin
                        if (b == C_MARK) begin
                            n_phase = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        priority if (b == C_MARK) begin
                            n_phase = PH_CODE;
                        end else if (is_sof) begin
                            n_phase = PH_FRAME;
                            n_field = 3'd0;
                        end else if (b == C_SOS || b == C_EOI) begin
                            done   = 1'b1;
                            status = ST_NOFRAME;
                        end else begin
                            n_phase = PH_LENHI;
                        end
                    end
                    PH_LENHI: begin
                        n_seg_len = {b, 8'h00};
                        n_phase   = PH_LENLO;
                    end
                    PH_LENLO: begin
                        n_seg_len = len_word;
                        if (len_word < C_LEN_MIN) begin
                            done   = 1'b1;
                            status = ST_BADLEN;
                        end else begin
                            n_skip  = len_word - C_LEN_MIN;
                            n_phase = (len_word == C_LEN_MIN) ? PH_HUNT : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        n_skip = r_skip - 16'd1;
                        if (r_skip == 16'd1) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_FRAME: begin
                        unique case (field_eff)
                            3'd0: n_seg_len = {b, 8'h00};
                            3'd1: n_seg_len = {r_seg_len[15:8], b};
                            3'd2: n_seg_len = r_seg_len;
                            3'd3: n_height  = {b, 8'h00};
                            3'd4: n_height  = {r_height[15:8], b};
                            3'd5: n_width   = {b, 8'h00};
                            3'd6: n_width   = {r_width[15:8], b};
                            default: begin
                                done   = 1'b1;
                                status = (r_seg_len == len_need) ? ST_FOUND : ST_BADLEN;
                            end
                        endcase
                        n_field = field_eff + 3'd1;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
                if (!done && i_beat.last_byte) begin
                    done   = 1'b1;
                    status = ST_TRUNC;
                end
                if (done) begin
                    n_concluded = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SOI0;
            r_skip      <= 16'd0;
            r_field     <= 3'd0;
            r_concluded <= 1'b1;
        end else begin
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_field     <= n_field;
            r_concluded <= n_concluded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg_len <= n_seg_len;
        r_height  <= n_height;
        r_width   <= n_width;
    end

    assign o_res_valid = done;
    assign o_res.status = status;
    assign o_res.width  = (status == ST_FOUND) ? r_width  : 16'd0;
    assign o_res.height = (status == ST_FOUND) ? r_height : 16'd0;

endmodule

/* sv/jhds_out_reg.sv */
// Result register of the JPEG dimension scanner, holding one result beat.
// Depends on jhds_pkg.
module jhds_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  jhds_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_advance,
    output logic              o_valid,
    output jhds_pkg::t_result o_res
);
    import jhds_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can take a new result when empty or when its beat leaves now.
    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* sv/jpeg_header_dimension_scan_core.sv */
// Top level of the JPEG dimension scanner: input register, parser, result register.
// Depends on jhds_pkg, jhds_in_reg, jhds_parser and jhds_out_reg.
//
// Usage: the file is fed as byte beats on the input channel (i_valid, o_stall),
// with i_first_byte marking the first byte of a file and i_last_byte its last.
// A file must open with FF D8; the parser then walks the marker segments and
// reports once per file on the result channel (o_valid, i_stall): status 0 with
// width and height from a frame header, 1 on SOS or EOI without a frame,
// 2 on a bad start, 3 when the file ends early and 4 on a bad segment length.
// Width and height read zero for any status but 0.
// Throughput is one byte per cycle while o_stall is low. Each accepted byte
// passes the input register and the parser, and a result that it concludes
// goes to the result register. Bytes that conclude nothing pass through silently.
// After a report, bytes are ignored until the next first-byte beat; a
// first-byte beat in the middle of a file drops the old parse without a report.
// Reset returns to the ignoring state with no result pending.
// While the receiver stalls, the result beat holds and o_stall rises only when
// a byte waits in the input register behind that held result.
module jpeg_header_dimension_scan_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_width,
    output logic [15:0] o_height
);
    import jhds_pkg::*;

    t_beat   in_beat;
    t_beat   reg_beat;
    logic    reg_valid;
    logic    advance;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_beat.data_byte  = i_data_byte;
    assign in_beat.first_byte = i_first_byte;
    assign in_beat.last_byte  = i_last_byte;

    assign o_stall = reg_valid && !advance;

    jhds_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (!o_stall),
        .i_valid (i_valid),
        .i_beat  (in_beat),
        .o_valid (reg_valid),
        .o_beat  (reg_beat)
    );

    jhds_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (reg_valid && advance),
        .i_beat      (reg_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jhds_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_advance   (advance),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_status = out_res.status;
    assign o_width  = out_res.width;
    assign o_height = out_res.height;

endmodule

/* sv/jhds_checker.sv */
// Port-level checker of the JPEG dimension scanner, bound to the top level.
// Depends on jpeg_header_dimension_scan_core_assert.svh.
`include "jpeg_header_dimension_scan_core_assert.svh"

module jhds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_width,
    input logic [15:0] o_height
);

    // A held result beat keeps its payload.
    `JHDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_width) && $stable(o_height))

    // Input backpressure only comes from a stalled result beat.
    `JHDS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    `JHDS_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_valid, o_status <= 3'd4)

    // Dimensions are reported only with a found frame.
    `JHDS_ASSERT_NOW(a_dims_zero, i_clk, i_rst_n, o_valid && (o_status != 3'd0), (o_width == 16'd0) && (o_height == 16'd0))

endmodule

bind jpeg_header_dimension_scan_core jhds_checker u_jhds_checker (.*);

/* bench/tb_jpeg_header_dimension_scan_core.sv */
// Self-checking bench for the JPEG frame-dimension scanner: byte files in, at most one report per file.
// Depends on jhds_pkg and jpeg_header_dimension_scan_core; needs nothing else.
module tb_jpeg_header_dimension_scan_core;
    timeunit 1ns;
    timeprecision 1ps;

    import jhds_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int TARGET_BYTES = 650;
    localparam int TARGET_FILES = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       hold;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_width;
    logic [15:0] o_height;

    jpeg_header_dimension_scan_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_width      (o_width),
        .o_height     (o_height)
    );

    // Beats waiting to be sent and reports the scanner still owes us.
    t_pending   byte_beats[$];
    t_result    expected_reports[$];
    logic [7:0] file_bytes[$];

    // Mirror of the scanner state.
    t_phase      scan_phase;
    logic [15:0] skip_left;
    logic [2:0]  frame_field;
    logic [15:0] seg_len;
    logic [15:0] frame_h;
    logic [15:0] frame_w;
    logic [7:0]  comp_cnt;
    logic        parse_done;

    int       errors = 0;
    int       cycle_count = 0;
    int       queued_bytes = 0;
    int       files_queued = 0;
    int       bytes_accepted = 0;
    int       reports_checked = 0;
    int       status_seen[5] = '{default: 0};
    int       gap_left = 0;
    int       burst_left = 0;
    int       stall_mode = 0;
    int       mode_left = 0;
    t_pending next_beat;
    t_result  want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_sof(input logic [7:0] b);
        return b >= C_SOF_LO && b <= C_SOF_HI && b != C_DHT && b != C_JPG && b != C_DAC;
    endfunction

    function automatic logic [15:0] pick_dim();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        $display("MISMATCH %0s at report %0d: got %0d, expected %0d",
                 what, reports_checked, got, exp_val);
    endtask

    // Advances the mirrored parse by one accepted beat and records any report it causes.
    task automatic scan_byte(input logic [7:0] b, input logic first, input logic last);
        logic    fin;
        t_status st;
        t_result r;
        int      need;
        int      have;
        fin = 1'b0;
        st = ST_FOUND;
        if (first) begin
            scan_phase = PH_SOI0;
            skip_left = '0;
            frame_field = '0;
            seg_len = '0;
            frame_h = '0;
            frame_w = '0;
            comp_cnt = '0;
            parse_done = 1'b0;
        end
        if (!parse_done) begin
            case (scan_phase)
                PH_SOI0: begin
                    if (b == C_MARK) scan_phase = PH_SOI1;
                    else begin
                        fin = 1'b1;
                        st = ST_BADSTART;
                    end
                end
                PH_SOI1: begin
                    if (b == C_SOI) scan_phase = PH_HUNT;
                    else begin
                        fin = 1'b1;
                        st = ST_BADSTART;
                    end
                end
                PH_HUNT: begin
                    if (b == C_MARK) scan_phase = PH_CODE;
                end
                PH_CODE: begin
                    // Extra FF bytes are padding and keep us waiting for the code.
                    if (b != C_MARK) begin
                        if (is_sof(b)) begin
                            scan_phase = PH_FRAME;
                            frame_field = '0;
                        end else if (b == C_SOS || b == C_EOI) begin
                            fin = 1'b1;
                            st = ST_NOFRAME;
                        end else begin
                            scan_phase = PH_LENHI;
                        end
                    end
                end
                PH_LENHI: begin
                    seg_len = {b, 8'h00};
                    scan_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    seg_len = seg_len | {8'h00, b};
                    if (seg_len < C_LEN_MIN) begin
                        fin = 1'b1;
                        st = ST_BADLEN;
                    end else begin
                        skip_left = seg_len - C_LEN_MIN;
                        scan_phase = (skip_left == 16'd0) ? PH_HUNT : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) scan_phase = PH_HUNT;
                end
                PH_FRAME: begin
                    case (frame_field)
                        3'd0: seg_len = {b, 8'h00};
                        3'd1: seg_len = seg_len | {8'h00, b};
                        3'd2: ;
                        3'd3: frame_h = {b, 8'h00};
                        3'd4: frame_h = frame_h | {8'h00, b};
                        3'd5: frame_w = {b, 8'h00};
                        3'd6: frame_w = frame_w | {8'h00, b};
                        default: begin
                            comp_cnt = b;
                            need = int'(C_FRAME_FIX) + int'(C_COMP_LEN) * int'(comp_cnt);
                            have = int'(seg_len);
                            fin = 1'b1;
                            st = (have == need) ? ST_FOUND : ST_BADLEN;
                        end
                    endcase
                    frame_field = frame_field + 3'd1;
                end
                default: scan_phase = PH_HUNT;
            endcase
            if (!fin && last) begin
                fin = 1'b1;
                st = ST_TRUNC;
            end
            if (fin) begin
                parse_done = 1'b1;
                r.status = st;
                r.width = (st == ST_FOUND) ? frame_w : 16'd0;
                r.height = (st == ST_FOUND) ? frame_h : 16'd0;
                expected_reports.push_back(r);
            end
        end
    endtask

    task automatic push_beat(input logic [7:0] d, input logic f, input logic l, input logic h);
        t_pending p;
        p.data = d;
        p.first = f;
        p.last = l;
        p.hold = h;
        byte_beats.push_back(p);
        queued_bytes++;
    endtask

    // Sends file_bytes as one file; a negative last_at leaves it open so the next file
    // cuts it off.
    task automatic emit_file(input int last_at, input logic hold);
        int n;
        n = (last_at >= 0) ? last_at + 1 : file_bytes.size();
        for (int i = 0; i < n; i++) begin
            push_beat(file_bytes[i], i == 0, i == last_at, hold && i == 0);
        end
        files_queued++;
    endtask

    task automatic build_random_file(output int last_at);
        int          nseg;
        int          n;
        int          r;
        int          len;
        int          comp;
        logic [7:0]  code;
        logic [15:0] flen;
        logic [15:0] dim;
        logic        big;
        file_bytes.delete();
        big = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            code = 8'($urandom);
            file_bytes.push_back(code);
        end else if (r < 8) begin
            file_bytes.push_back(C_MARK);
            code = 8'($urandom);
            file_bytes.push_back(code);
        end else begin
            file_bytes.push_back(C_MARK);
            file_bytes.push_back(C_SOI);
        end
        nseg = $urandom_range(0, 3);
        for (int s = 0; s < nseg && !big; s++) begin
            if ($urandom_range(0, 9) < 3) begin
                repeat ($urandom_range(1, 2)) begin
                    code = 8'($urandom);
                    file_bytes.push_back(code);
                end
            end
            file_bytes.push_back(C_MARK);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 2)) file_bytes.push_back(C_MARK);
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: code = C_DHT;
                    1: code = C_JPG;
                    default: code = C_DAC;
                endcase
            end else begin
                code = 8'($urandom);
                while (code == C_MARK || code == C_SOS || code == C_EOI || is_sof(code))
                    code = 8'($urandom);
            end
            file_bytes.push_back(code);
            r = $urandom_range(0, 99);
            if (r < 4) len = $urandom_range(0, 1);
            else if (r < 8) begin
                len = $urandom_range(0, 65535);
                big = 1'b1;
            end else if (r < 12) len = $urandom_range(9, 60);
            else len = $urandom_range(2, 8);
            flen = 16'(len);
            file_bytes.push_back(flen[15:8]);
            file_bytes.push_back(flen[7:0]);
            // A huge length would take ages to skip, so such a file is cut short.
            if (big) n = $urandom_range(0, 5);
            else n = (len >= 2) ? len - 2 : 0;
            repeat (n) begin
                code = 8'($urandom);
                file_bytes.push_back(code);
            end
        end
        if (!big) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                file_bytes.push_back(C_MARK);
                code = 8'(C_SOF_LO + $urandom_range(0, 15));
                while (!is_sof(code)) code = 8'(C_SOF_LO + $urandom_range(0, 15));
                file_bytes.push_back(code);
                comp = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 4);
                flen = 16'(C_FRAME_FIX + C_COMP_LEN * comp);
                if ($urandom_range(0, 5) == 0) begin
                    if ($urandom_range(0, 1) == 0) flen = 16'(flen + $urandom_range(1, 3));
                    else flen = 16'($urandom);
                end
                file_bytes.push_back(flen[15:8]);
                file_bytes.push_back(flen[7:0]);
                code = 8'($urandom);
                file_bytes.push_back(code);
                dim = pick_dim();
                file_bytes.push_back(dim[15:8]);
                file_bytes.push_back(dim[7:0]);
                dim = pick_dim();
                file_bytes.push_back(dim[15:8]);
                file_bytes.push_back(dim[7:0]);
                code = 8'(comp);
                file_bytes.push_back(code);
            end else if (r < 8) begin
                file_bytes.push_back(C_MARK);
                if ($urandom_range(0, 3) == 0) file_bytes.push_back(C_MARK);
                file_bytes.push_back(($urandom_range(0, 1) == 0) ? C_SOS : C_EOI);
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    code = 8'($urandom);
                    file_bytes.push_back(code);
                end
            end
        end
        n = file_bytes.size();
        r = $urandom_range(0, 99);
        if (big || r < 75) last_at = n - 1;
        else if (r < 90) last_at = $urandom_range(0, n - 1);
        else last_at = -1;
    endtask

    // Driver: sends beats in bursts with gaps and predicts each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data_byte <= 8'h00;
            i_first_byte <= 1'b0;
            i_last_byte <= 1'b0;
            scan_phase = PH_SOI0;
            skip_left = '0;
            frame_field = '0;
            seg_len = '0;
            frame_h = '0;
            frame_w = '0;
            comp_cnt = '0;
            parse_done = 1'b1;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                scan_byte(i_data_byte, i_first_byte, i_last_byte);
                bytes_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (byte_beats.size() == 0 ||
                             (byte_beats[0].hold && expected_reports.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    next_beat = byte_beats.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= next_beat.data;
                    i_first_byte <= next_beat.first;
                    i_last_byte <= next_beat.last;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left = $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Monitor: checks each accepted report beat and stalls on a changing pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected report, status", int'(o_status), -1);
                end else begin
                    want = expected_reports.pop_front();
                    if (o_status != want.status)
                        report_mismatch("status", int'(o_status), int'(want.status));
                    if (o_width != want.width)
                        report_mismatch("width", int'(o_width), int'(want.width));
                    if (o_height != want.height)
                        report_mismatch("height", int'(o_height), int'(want.height));
                    status_seen[want.status]++;
                end
                reports_checked++;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 99) < 35);
                default: i_stall <= ((mode_left % 16) < 10);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int last_at;
        logic [7:0] stray;

        // Directed files. A stray beat right after reset must be ignored.
        push_beat(8'h5A, 1'b0, 1'b0, 1'b0);
        file_bytes = '{C_MARK, C_SOI, C_MARK, C_SOF_LO, 8'h00, 8'h08, 8'h00,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        emit_file(11, 1'b0);
        // Bad first byte, sent only once everything before it has reported.
        file_bytes = '{8'h00};
        emit_file(-1, 1'b1);
        // One-beat file that ends right after a good first byte.
        file_bytes = '{C_MARK};
        emit_file(0, 1'b0);
        file_bytes = '{C_MARK, 8'h00};
        emit_file(-1, 1'b0);
        // Padding before SOS, concluding on the last beat.
        file_bytes = '{C_MARK, C_SOI, C_MARK, C_MARK, C_SOS};
        emit_file(4, 1'b0);
        // Segment length below the minimum.
        file_bytes = '{C_MARK, C_SOI, C_MARK, 8'hFE, 8'h00, 8'h01};
        emit_file(-1, 1'b0);

        while (queued_bytes < TARGET_BYTES || files_queued < TARGET_FILES) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    stray = 8'($urandom);
                    push_beat(stray, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
                end
            end
            build_random_file(last_at);
            emit_file(last_at, $urandom_range(0, 11) == 0);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (byte_beats.size() != 0 || i_valid);
        for (int w = 0; w < DRAIN_LIMIT && expected_reports.size() != 0; w++)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (expected_reports.size() != 0) begin
            want = expected_reports.pop_front();
            report_mismatch("missing report, status", -1, int'(want.status));
        end

        $display("Scanned %0d bytes in %0d files; %0d reports checked.",
                 bytes_accepted, files_queued, reports_checked);
        $display("Reports: found %0d, no frame %0d, bad start %0d, truncated %0d, bad len %0d",
                 status_seen[ST_FOUND], status_seen[ST_NOFRAME], status_seen[ST_BADSTART],
                 status_seen[ST_TRUNC], status_seen[ST_BADLEN]);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
